FILE: design/mcctb_pkg.sv
package mcctb_pkg;

	// Action codes of a command word.
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_CONFIG  = 3'd1;
	localparam logic [2:0] ACT_START   = 3'd2;
	localparam logic [2:0] ACT_STOP    = 3'd3;
	localparam logic [2:0] ACT_SERVICE = 3'd4;

	// Event kinds of a result word.
	localparam logic [1:0] KIND_HARD     = 2'd0;
	localparam logic [1:0] KIND_WAKE     = 2'd1;
	localparam logic [1:0] KIND_SERVICED = 2'd2;

	// Mode bit positions.
	localparam int MODE_CONT = 0;
	localparam int MODE_HARD = 1;

	localparam int BANK_SIZE = 16;
	localparam logic [9:0] SEC_SCALE = 10'd1000;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  channel;
		logic [31:0] reload_value;
		logic        continuous;
		logic        seconds_base;
		logic        hard_mode;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] event_channel;
		logic [1:0] event_kind;
		logic       last_event;
	} evt_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

FILE: design/multi_channel_countdown_timer_bank_top.sv
// Channel  Handshake              Word
// cmd      start / busy           mcctb_pkg::cmd_word_t
// result   strobe (one cycle)     mcctb_pkg::evt_word_t
//
// Configure and stop complete at the accepting edge; busy stays low.
// Start adds the ST_START state: the reload memory read, then the counter write.
// Tick and service sweep the channels one per cycle through the counter and
// reload memories, so busy stays high through the sweep and the flush state.
// Each event leaves in the cycle after the next one is found, the final one
// after the sweep. Reset clears the masks and the reload valid bits at once.
// The receiver cannot stall; events are never held back.
module multi_channel_countdown_timer_bank_top #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mcctb_pkg::cmd_word_t  cmd,
	output logic                  strobe,
	output mcctb_pkg::evt_word_t  result
);
	import mcctb_pkg::*;

	localparam int ACTIVE = (NUM_CHANNELS > BANK_SIZE) ? BANK_SIZE : NUM_CHANNELS;
	localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	state_t state_q, state_nx;

	logic [ACTIVE-1:0] run_q, pend_q, cfg_vld_q;
	logic [ACTIVE-1:0] run_nx, pend_nx, cfg_vld_nx;
	logic [IDX_W-1:0]  idx_s1, ch_q;
	logic [2:0]        op_q;

	// Reload memory: {mode, reload}. Counter memory.
	logic [33:0]       rl_mem [ACTIVE];
	logic [31:0]       cnt_mem [ACTIVE];
	logic [33:0]       rl_rd_q;
	logic              rl_vld_rd_q;
	logic [31:0]       cnt_rd_q;

	logic              rl_we, cnt_we;
	logic [IDX_W-1:0]  rl_wa, rd_a, cnt_wa;
	logic [33:0]       rl_wd;
	logic [31:0]       cnt_wd;

	logic              accept, ch_ok, last_idx;
	logic [IDX_W-1:0]  cmd_idx;
	logic [41:0]       prod;
	logic [31:0]       scaled;
	logic [1:0]        mode_rd;
	logic [31:0]       reload_rd;

	logic              evt_found;
	logic [1:0]        evt_kind;
	logic              hold_vld_q, hold_vld_nx;
	logic [IDX_W-1:0]  hold_ch_q;
	logic [1:0]        hold_kind_q;
	logic              out_fire;
	evt_word_t         out_word, result_q;
	logic              strobe_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign ch_ok    = ({1'b0, cmd.channel} < 5'(ACTIVE));
	assign cmd_idx  = cmd.channel[IDX_W-1:0];
	assign last_idx = (idx_s1 == IDX_W'(ACTIVE - 1));

	assign prod   = {10'd0, cmd.reload_value} * {32'd0, SEC_SCALE};
	assign scaled = cmd.seconds_base ? ((|prod[41:32]) ? 32'hFFFF_FFFF : prod[31:0])
	                                 : cmd.reload_value;

	// An entry never configured reads as reload zero, single shot soft.
	assign mode_rd   = rl_vld_rd_q ? rl_rd_q[33:32] : 2'b00;
	assign reload_rd = rl_vld_rd_q ? rl_rd_q[31:0] : 32'd0;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.action) inside
						ACT_TICK, ACT_SERVICE: state_nx = ST_SCAN;
						ACT_START:             state_nx = ch_ok ? ST_START : ST_IDLE;
						default:               state_nx = ST_IDLE;
					endcase
				end
			end
			ST_START: state_nx = ST_IDLE;
			ST_SCAN:  state_nx = last_idx ? ST_FLUSH : ST_SCAN;
			ST_FLUSH: state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		run_nx      = run_q;
		pend_nx     = pend_q;
		cfg_vld_nx  = cfg_vld_q;
		rl_we       = 1'b0;
		rl_wa       = cmd_idx;
		rl_wd       = {cmd.hard_mode, cmd.continuous, scaled};
		rd_a        = idx_s1;
		cnt_we      = 1'b0;
		cnt_wa      = idx_s1;
		cnt_wd      = 32'd0;
		evt_found   = 1'b0;
		evt_kind    = KIND_HARD;
		hold_vld_nx = hold_vld_q;
		out_fire    = 1'b0;
		out_word    = '{event_channel: 4'(hold_ch_q), event_kind: hold_kind_q,
		                last_event: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				rd_a = {IDX_W{1'b0}};
				if (accept) begin
					case (cmd.action)
						ACT_CONFIG: begin
							if (ch_ok) begin
								rl_we               = 1'b1;
								cfg_vld_nx[cmd_idx] = 1'b1;
								run_nx[cmd_idx]     = 1'b0;
								pend_nx[cmd_idx]    = 1'b0;
							end
						end
						ACT_STOP: begin
							if (ch_ok) begin
								run_nx[cmd_idx]  = 1'b0;
								pend_nx[cmd_idx] = 1'b0;
							end
						end
						ACT_START: rd_a = cmd_idx;
						default: ;
					endcase
				end
			end
			ST_START: begin
				cnt_we        = 1'b1;
				cnt_wa        = ch_q;
				cnt_wd        = reload_rd;
				run_nx[ch_q]  = 1'b1;
				pend_nx[ch_q] = 1'b0;
			end
			ST_SCAN: begin
				rd_a = idx_s1 + IDX_W'(1);
				if (op_q == ACT_TICK) begin
					if (run_q[idx_s1]) begin
						if (cnt_rd_q > 32'd1) begin
							cnt_we = 1'b1;
							cnt_wd = cnt_rd_q - 32'd1;
						end else if (mode_rd[MODE_HARD]) begin
							evt_found = 1'b1;
							evt_kind  = KIND_HARD;
							if (mode_rd[MODE_CONT]) begin
								cnt_we = 1'b1;
								cnt_wd = reload_rd;
							end else begin
								run_nx[idx_s1] = 1'b0;
							end
						end else begin
							evt_found       = 1'b1;
							evt_kind        = KIND_WAKE;
							run_nx[idx_s1]  = 1'b0;
							pend_nx[idx_s1] = 1'b1;
						end
					end
				end else begin
					if (pend_q[idx_s1]) begin
						evt_found       = 1'b1;
						evt_kind        = KIND_SERVICED;
						pend_nx[idx_s1] = 1'b0;
						if (mode_rd[MODE_CONT]) begin
							cnt_we         = 1'b1;
							cnt_wd         = reload_rd;
							run_nx[idx_s1] = 1'b1;
						end
					end
				end
				// The held word goes out once a later one shows it is not the last.
				if (evt_found) begin
					out_fire    = hold_vld_q;
					hold_vld_nx = 1'b1;
				end
			end
			ST_FLUSH: begin
				out_fire            = hold_vld_q;
				out_word.last_event = 1'b1;
				hold_vld_nx         = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_q      <= '0;
			pend_q     <= '0;
			cfg_vld_q  <= '0;
			hold_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_nx;
			run_q      <= run_nx;
			pend_q     <= pend_nx;
			cfg_vld_q  <= cfg_vld_nx;
			hold_vld_q <= hold_vld_nx;
			strobe_q   <= out_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.action;
			ch_q   <= cmd_idx;
			idx_s1 <= {IDX_W{1'b0}};
		end else if (state_q == ST_SCAN) begin
			idx_s1 <= idx_s1 + IDX_W'(1);
		end
		if (evt_found) begin
			hold_ch_q   <= idx_s1;
			hold_kind_q <= evt_kind;
		end
		if (out_fire) begin
			result_q <= out_word;
		end
	end

	always_ff @(posedge clk) begin
		if (rl_we) begin
			rl_mem[rl_wa] <= rl_wd;
		end
		rl_rd_q     <= rl_mem[rd_a];
		rl_vld_rd_q <= cfg_vld_q[rd_a];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[rd_a];
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
